// ----- rtl/cdq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int DEPTH = 128;
    localparam int CELLS = DEPTH - 1;

    typedef enum logic [2:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        LANE_HOLD   = 2'd0,
        LANE_SHR    = 2'd1,
        LANE_SHL    = 2'd2,
        LANE_APPEND = 2'd3
    } t_lane_op;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_cnt_op;

    typedef struct packed {
        t_lane_op   f_op;
        t_lane_op   r_op;
        t_cnt_op    cnt_op;
        logic [7:0] item;
    } t_cell_cmd;

    typedef struct packed {
        t_op        operation;
        logic [7:0] item;
    } t_in_word;

    typedef struct packed {
        logic [7:0] value;
        t_status    status;
        logic       empty_flag;
        logic       full_flag;
    } t_out_word;

endpackage

`default_nettype wire

// ----- rtl/cdq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cdq_pkg::t_cell_cmd i_cmd,
    input  wire logic [7:0]        i_f_left,
    input  wire logic [7:0]        i_r_left,
    input  wire logic              i_v_left,
    input  wire logic [7:0]        i_f_right,
    input  wire logic [7:0]        i_r_right,
    input  wire logic              i_v_right,
    output logic [7:0]             o_f,
    output logic [7:0]             o_r,
    output logic                   o_v
);

    logic [7:0] r_f;
    logic [7:0] r_r;
    logic       r_v;
    logic [7:0] n_f;
    logic [7:0] n_r;
    logic       n_v;
    logic       at_end;

    // This cell is the first free slot when its left neighbor holds an item and it does not.
    assign at_end = i_v_left && !r_v;

    always_comb begin
        case (i_cmd.f_op)
            cdq_pkg::LANE_SHR:    n_f = i_f_left;
            cdq_pkg::LANE_SHL:    n_f = i_f_right;
            cdq_pkg::LANE_APPEND: n_f = at_end ? i_cmd.item : r_f;
            default:              n_f = r_f;
        endcase
        case (i_cmd.r_op)
            cdq_pkg::LANE_SHR:    n_r = i_r_left;
            cdq_pkg::LANE_SHL:    n_r = i_r_right;
            cdq_pkg::LANE_APPEND: n_r = at_end ? i_cmd.item : r_r;
            default:              n_r = r_r;
        endcase
        case (i_cmd.cnt_op)
            cdq_pkg::CNT_INC: n_v = i_v_left;
            cdq_pkg::CNT_DEC: n_v = i_v_right;
            default:          n_v = r_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        r_r <= n_r;
    end

    assign o_f = r_f;
    assign o_r = r_r;
    assign o_v = r_v;

endmodule

`default_nettype wire

// ----- rtl/circular_deque.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Valid        Stall        Word
// input    in         i_in_valid   o_in_stall   i_in_word  (operation, item)
// output   out        o_out_valid  i_out_stall  o_out_word (value, status, flags)
//
// A new word is accepted each cycle while the output register is free or being drained,
// set by the single update of the cell row.
// The row holds the front-first and rear-first copies of the contents side by side.
// Reset empties the row at once; no clearing pass is needed.
// A stalled output word holds the input side stalled in the same cycle.

module circular_deque (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire cdq_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cdq_pkg::t_out_word     o_out_word
);

    logic [7:0]           cell_f [cdq_pkg::CELLS];
    logic [7:0]           cell_r [cdq_pkg::CELLS];
    logic                 cell_v [cdq_pkg::CELLS];
    cdq_pkg::t_cell_cmd   cmd;
    cdq_pkg::t_out_word   n_out_word;
    cdq_pkg::t_out_word   r_out_word;
    logic                 r_out_valid;
    logic                 accept;
    logic                 row_empty;
    logic                 is_full;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign row_empty  = !cell_v[0];
    assign is_full    = cell_v[cdq_pkg::CELLS-1];

    always_comb begin
        cmd.f_op   = cdq_pkg::LANE_HOLD;
        cmd.r_op   = cdq_pkg::LANE_HOLD;
        cmd.cnt_op = cdq_pkg::CNT_HOLD;
        cmd.item   = i_in_word.item;
        n_out_word.value  = 8'd0;
        n_out_word.status = cdq_pkg::ST_OK;
        unique case (i_in_word.operation)
            cdq_pkg::OP_PUSH_REAR: begin
                if (is_full) begin
                    n_out_word.status = cdq_pkg::ST_FULL;
                end else begin
                    cmd.f_op   = cdq_pkg::LANE_APPEND;
                    cmd.r_op   = cdq_pkg::LANE_SHR;
                    cmd.cnt_op = cdq_pkg::CNT_INC;
                end
            end
            cdq_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_out_word.status = cdq_pkg::ST_FULL;
                end else begin
                    cmd.f_op   = cdq_pkg::LANE_SHR;
                    cmd.r_op   = cdq_pkg::LANE_APPEND;
                    cmd.cnt_op = cdq_pkg::CNT_INC;
                end
            end
            cdq_pkg::OP_POP_FRONT: begin
                if (row_empty) begin
                    n_out_word.status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_out_word.value = cell_f[0];
                    cmd.f_op   = cdq_pkg::LANE_SHL;
                    cmd.cnt_op = cdq_pkg::CNT_DEC;
                end
            end
            cdq_pkg::OP_POP_REAR: begin
                if (row_empty) begin
                    n_out_word.status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_out_word.value = cell_r[0];
                    cmd.r_op   = cdq_pkg::LANE_SHL;
                    cmd.cnt_op = cdq_pkg::CNT_DEC;
                end
            end
            cdq_pkg::OP_PEEK_FRONT: begin
                if (row_empty) begin
                    n_out_word.status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_out_word.value = cell_f[0];
                end
            end
            cdq_pkg::OP_PEEK_REAR: begin
                if (row_empty) begin
                    n_out_word.status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_out_word.value = cell_r[0];
                end
            end
            default: begin
            end
        endcase
        case (cmd.cnt_op)
            cdq_pkg::CNT_INC: begin
                n_out_word.empty_flag = 1'b0;
                n_out_word.full_flag  = cell_v[cdq_pkg::CELLS-2];
            end
            cdq_pkg::CNT_DEC: begin
                n_out_word.empty_flag = !cell_v[1];
                n_out_word.full_flag  = 1'b0;
            end
            default: begin
                n_out_word.empty_flag = row_empty;
                n_out_word.full_flag  = is_full;
            end
        endcase
        if (!accept) begin
            cmd.f_op   = cdq_pkg::LANE_HOLD;
            cmd.r_op   = cdq_pkg::LANE_HOLD;
            cmd.cnt_op = cdq_pkg::CNT_HOLD;
        end
    end

    for (genvar i = 0; i < cdq_pkg::CELLS; i++) begin : g_cell
        logic [7:0] f_left;
        logic [7:0] r_left;
        logic       v_left;
        logic [7:0] f_right;
        logic [7:0] r_right;
        logic       v_right;

        if (i == 0) begin : g_first
            assign f_left = i_in_word.item;
            assign r_left = i_in_word.item;
            assign v_left = 1'b1;
        end else begin : g_inner_left
            assign f_left = cell_f[i-1];
            assign r_left = cell_r[i-1];
            assign v_left = cell_v[i-1];
        end

        if (i == cdq_pkg::CELLS - 1) begin : g_last
            assign f_right = 8'd0;
            assign r_right = 8'd0;
            assign v_right = 1'b0;
        end else begin : g_inner_right
            assign f_right = cell_f[i+1];
            assign r_right = cell_r[i+1];
            assign v_right = cell_v[i+1];
        end

        cdq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .i_f_left  (f_left),
            .i_r_left  (r_left),
            .i_v_left  (v_left),
            .i_f_right (f_right),
            .i_r_right (r_right),
            .i_v_right (v_right),
            .o_f       (cell_f[i]),
            .o_r       (cell_r[i]),
            .o_v       (cell_v[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(row_empty && is_full))
        else $error("deque reports empty and full at once");

    a_push_fills_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_full && (i_in_word.operation == cdq_pkg::OP_PUSH_REAR ||
         i_in_word.operation == cdq_pkg::OP_PUSH_FRONT)) |=> cell_v[0])
        else $error("accepted push left the deque empty");

    a_pop_front_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !row_empty && i_in_word.operation == cdq_pkg::OP_POP_FRONT)
        |=> (o_out_word.value == $past(cell_f[0])))
        else $error("pop front returned a byte other than the front cell");

    a_full_status_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == cdq_pkg::ST_FULL) |-> o_out_word.full_flag)
        else $error("refused push without full flag");

    a_empty_status_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == cdq_pkg::ST_EMPTY) |-> o_out_word.empty_flag)
        else $error("refused pop or peek without empty flag");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import cdq_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    class deque_scoreboard;
        logic [7:0] slots [DEPTH];
        int head_idx;
        int tail_idx;
        t_out_word expected_q[$];
        int errors;
        int checked;
        int refused_push;
        int refused_read;

        function new();
            head_idx = 0;
            tail_idx = 0;
            errors = 0;
            checked = 0;
            refused_push = 0;
            refused_read = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function bit ring_empty();
            return head_idx == tail_idx;
        endfunction

        function bit is_full();
            return ((tail_idx + 1) % DEPTH) == head_idx;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(t_in_word w);
            t_out_word e;
            e.value = '0;
            e.status = ST_OK;
            case (w.operation)
                OP_PUSH_REAR: begin
                    if (is_full()) begin
                        e.status = ST_FULL;
                    end else begin
                        tail_idx = (tail_idx + 1) % DEPTH;
                        slots[tail_idx] = w.item;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (is_full()) begin
                        e.status = ST_FULL;
                    end else begin
                        slots[head_idx] = w.item;
                        head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    end
                end
                OP_POP_FRONT: begin
                    if (ring_empty()) begin
                        e.status = ST_EMPTY;
                    end else begin
                        head_idx = (head_idx + 1) % DEPTH;
                        e.value = slots[head_idx];
                    end
                end
                OP_POP_REAR: begin
                    if (ring_empty()) begin
                        e.status = ST_EMPTY;
                    end else begin
                        e.value = slots[tail_idx];
                        tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                    end
                end
                OP_PEEK_FRONT: begin
                    if (ring_empty()) begin
                        e.status = ST_EMPTY;
                    end else begin
                        e.value = slots[(head_idx + 1) % DEPTH];
                    end
                end
                OP_PEEK_REAR: begin
                    if (ring_empty()) begin
                        e.status = ST_EMPTY;
                    end else begin
                        e.value = slots[tail_idx];
                    end
                end
                default: begin
                end
            endcase
            if (e.status == ST_FULL) begin
                refused_push++;
            end else if (e.status == ST_EMPTY) begin
                refused_read++;
            end
            e.empty_flag = ring_empty();
            e.full_flag = is_full();
            expected_q.push_back(e);
        endfunction

        function void report(string field, logic [7:0] e, logic [7:0] a);
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, e, a);
        endfunction

        function void check_result(t_out_word got);
            t_out_word e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result word %h arrived with nothing expected", $time, got);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.value !== e.value) report("value", e.value, got.value);
            if (got.status !== e.status) report("status", 8'(e.status), 8'(got.status));
            if (got.empty_flag !== e.empty_flag) begin
                report("empty_flag", 8'(e.empty_flag), 8'(got.empty_flag));
            end
            if (got.full_flag !== e.full_flag) begin
                report("full_flag", 8'(e.full_flag), 8'(got.full_flag));
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int words_sent = 0;
    int quiet_cycles = 0;

    deque_scoreboard sb = new();

    circular_deque DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic t_in_word make_word(t_op op, logic [7:0] item);
        t_in_word w;
        w.operation = op;
        w.item = item;
        return w;
    endfunction

    function automatic t_in_word rand_word(int push_pct);
        t_in_word w;
        w.item = 8'($urandom_range(255));
        if ($urandom_range(99) < push_pct) begin
            w.operation = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        end else begin
            case ($urandom_range(5))
                0, 1: w.operation = OP_POP_FRONT;
                2, 3: w.operation = OP_POP_REAR;
                4: w.operation = OP_PEEK_FRONT;
                default: w.operation = OP_PEEK_REAR;
            endcase
        end
        return w;
    endfunction

    function automatic t_in_word rand_pop();
        t_in_word w;
        w.item = 8'($urandom_range(255));
        w.operation = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(OP_POP_FRONT, 8'hFF));
        send_word(make_word(OP_POP_REAR, 8'hFF));
        send_word(make_word(OP_PEEK_FRONT, 8'h00));
        send_word(make_word(OP_PEEK_REAR, 8'h00));
        send_word(make_word(OP_PUSH_REAR, 8'h00));
        send_word(make_word(OP_PUSH_FRONT, 8'hFF));
        send_word(make_word(OP_PUSH_REAR, 8'hA5));
        send_word(make_word(OP_PUSH_FRONT, 8'h5A));
        send_word(make_word(OP_PEEK_FRONT, 8'h00));
        send_word(make_word(OP_PEEK_REAR, 8'hFF));
        send_word(make_word(OP_POP_FRONT, 8'h00));
        send_word(make_word(OP_POP_REAR, 8'h00));
        send_word(make_word(OP_POP_FRONT, 8'h00));
        send_word(make_word(OP_POP_REAR, 8'h00));
        send_word(make_word(OP_POP_FRONT, 8'h00));
        send_word(make_word(OP_PUSH_FRONT, 8'h80));
        send_word(make_word(OP_POP_FRONT, 8'h00));
        send_word(make_word(OP_PUSH_REAR, 8'h01));
        send_word(make_word(OP_POP_REAR, 8'h00));
        send_word(make_word(OP_PEEK_REAR, 8'h00));
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 31 : (p == 1) ? 63 : 0;
            rx_idle_pct = (p == 0) ? 63 : (p == 1) ? 31 : 0;
            // Fill to capacity, push against the full ring, mix, then drain past empty.
            while (!sb.is_full()) send_word(rand_word(100));
            repeat (8) send_word(rand_word(75));
            repeat (20) send_word(rand_word(50));
            while (!sb.ring_empty()) send_word(rand_pop());
            repeat (8) send_word(rand_word(20));
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d words and checked %0d results over three stall patterns.",
                 words_sent, sb.checked);
        $display("The deque filled and emptied repeatedly: %0d pushes refused, %0d reads refused.",
                 sb.refused_push, sb.refused_read);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque.sv
test/tb_top.sv
